/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the PI loop block; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, disabled while reset is low
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked property, checked in every cycle
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/pilp_pkg.sv */
// ----------------------------------------------------------------------------
// pilp_pkg
// Shared widths, constants, types and helpers of the PI loop block.
// ----------------------------------------------------------------------------
package pilp_pkg;

    // field widths
    localparam int NOW_W      = 32;
    localparam int SP_W       = 22;
    localparam int PV_W       = 21;
    localparam int ERR_W      = 23;
    localparam int UP_W       = 30;
    localparam int SUM_W      = 40;
    localparam int LIM_W      = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // shared multiplier and divider
    localparam int MUL_A_W   = 22;
    localparam int MUL_B_W   = 16;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DIVD_W    = MUL_P_W;
    localparam int DVS_W     = 16;
    localparam int QUOT_W    = DIVD_W + 1;
    localparam int DIV_RADIX = 2;
    localparam int DIV_STEPS = DIVD_W / DIV_RADIX;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // setpoint profile
    localparam int PROFILE_N = 4;
    localparam int IDX_W     = $clog2(PROFILE_N + 1);
    localparam logic [DVS_W-1:0] HOLD_MS       = DVS_W'(5000);
    localparam logic [DVS_W-1:0] PROFILE_STEPS = DVS_W'(PROFILE_N);
    localparam logic [DVS_W-1:0] MILLI         = DVS_W'(1000);

    // limits
    localparam logic [LIM_W-1:0] LIMIT_MAX = LIM_W'(1000000);
    localparam logic [LIM_W-1:0] PV_MAX    = LIM_W'(1000000);
    localparam logic [LIM_W-1:0] SP_MAX    = LIM_W'(2000000);
    localparam logic [NOW_W-1:0] DT_CAP    = NOW_W'(65535);
    localparam logic signed [SUM_W-1:0] PV_BOUND    = SUM_W'(PV_MAX);
    localparam logic signed [SUM_W-1:0] INTEG_BOUND = SUM_W'(LIMIT_MAX);

    // register reset values
    localparam logic [15:0]        RST_PROP_GAIN  = 16'd800;
    localparam logic [15:0]        RST_INTEG_GAIN = 16'd150;
    localparam logic [15:0]        RST_TAU        = 16'd1000;
    localparam logic [19:0]        RST_DRIVE_LIM  = 20'd200000;
    localparam logic [19:0]        RST_INTEG_LIM  = 20'd200000;
    localparam logic [15:0]        RST_PERIOD     = 16'd10;
    localparam logic signed [20:0] RST_SP_BASE    = 21'sd60000;
    localparam logic signed [18:0] RST_SP_STRIDE  = 19'sd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_PLANT_TAU  = 3'd2,
        CFG_DRIVE_LIM  = 3'd3,
        CFG_INTEG_LIM  = 3'd4,
        CFG_PERIOD     = 3'd5,
        CFG_SP_BASE    = 3'd6,
        CFG_SP_STRIDE  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HOLD_DIV,
        S_STEP_DIV,
        S_SP,
        S_ERR,
        S_INT_MUL,
        S_INT_DIV,
        S_P_DIV,
        S_I_MUL,
        S_I_DIV,
        S_DIFF,
        S_PV_MUL,
        S_PV_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DIVD_W-1:0] dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [DVS_W-1:0]  rem;
    } t_div_rsp;

    function automatic logic signed [SUM_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

/* rtl/pilp_div.sv */
// ----------------------------------------------------------------------------
// pilp_div
// Shared radix-4 restoring divider, truncating toward zero via sign-magnitude.
// ----------------------------------------------------------------------------
module pilp_div import pilp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic             r_neg;

    logic [DVS_W-1:0]  n_rem;
    logic [DIVD_W-1:0] n_quo;
    logic [DVS_W:0]    trial;
    logic signed [QUOT_W-1:0] quot_mag;

    // two quotient bits per cycle; remainder stays below the divisor
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int k = 0; k < DIV_RADIX; k++) begin
            trial = {n_rem, n_quo[DIVD_W-1]};
            n_quo = {n_quo[DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                trial    = trial - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign quot_mag   = $signed({1'b0, r_quo});
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? QUOT_W'(-quot_mag) : QUOT_W'(quot_mag);
    assign o_rsp.rem  = r_rem;

endmodule

/* rtl/pi_loop_with_plant_model.sv */
// ----------------------------------------------------------------------------
// pi_loop_with_plant_model
// One PI control iteration with a first-order plant per time stamp item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item: a millisecond
//   wall clock stamp. Output channel (o_out_valid / i_out_ready) returns one
//   item per input: setpoint, plant value, drive, integral, gap stats and iteration count.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//   the user must write it only while the block is idle, and the block
//   itself does not enforce this. Timing: an item runs six serial divisions
//   on one shared divider (two quotient bits per cycle over a 38-bit
//   dividend), plus steps on the shared 22x16 multiplier. The next item is
//   accepted only after the last result has moved into the output register.
//   The output register frees the input side: the next item is accepted
//   while a result still waits. If the receiver stalls, the following item
//   finishes its math and holds until the output register is free.
//   Reset (synchronous, active low) loads the register defaults and clears
//   the loop state and statistics; the first item uses one period as gap.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pi_loop_with_plant_model import pilp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [NOW_W-1:0]        i_now_ms,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [SP_W-1:0]  o_setpoint_milli,
    output logic signed [PV_W-1:0]  o_measured_milli,
    output logic signed [PV_W-1:0]  o_drive_milli,
    output logic signed [PV_W-1:0]  o_integral_milli,
    output logic [NOW_W-1:0]        o_gap_ms,
    output logic [NOW_W-1:0]        o_worst_gap_ms,
    output logic [NOW_W-1:0]        o_overrun_count,
    output logic [NOW_W-1:0]        o_iteration_count
);

    // configuration
    logic [15:0]        r_prop_gain;
    logic [15:0]        r_integ_gain;
    logic [15:0]        r_tau;
    logic [19:0]        r_drive_lim;
    logic [19:0]        r_integ_lim;
    logic [15:0]        r_period;
    logic signed [20:0] r_sp_base;
    logic signed [18:0] r_sp_stride;

    // loop state
    t_state                  r_state;
    t_state                  n_state;
    logic                    r_first;
    logic [NOW_W-1:0]        r_last_stamp;
    logic signed [PV_W-1:0]  r_pv;
    logic signed [PV_W-1:0]  r_integ;
    logic [NOW_W-1:0]        r_worst;
    logic [NOW_W-1:0]        r_overruns;
    logic [NOW_W-1:0]        r_iterations;

    // per-item working registers
    logic [NOW_W-1:0]        r_gap;
    logic [15:0]             r_dt;
    logic [IDX_W-1:0]        r_idx;
    logic signed [SP_W-1:0]  r_sp;
    logic signed [ERR_W-1:0] r_err;
    logic signed [UP_W-1:0]  r_up;
    logic signed [PV_W-1:0]  r_u;

    // output register
    logic                    r_o_valid;
    logic signed [SP_W-1:0]  r_o_sp;
    logic signed [PV_W-1:0]  r_o_pv;
    logic signed [PV_W-1:0]  r_o_u;
    logic signed [PV_W-1:0]  r_o_integ;
    logic [NOW_W-1:0]        r_o_gap;
    logic [NOW_W-1:0]        r_o_worst;
    logic [NOW_W-1:0]        r_o_overruns;
    logic [NOW_W-1:0]        r_o_iterations;

    logic             in_accept;
    logic             out_load;
    logic [15:0]      per_eff;
    logic [15:0]      tau_eff;
    logic [LIM_W-1:0] dlim_eff;
    logic [LIM_W-1:0] ilim_eff;
    logic [NOW_W-1:0] gap;
    logic [15:0]      dt_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic [18:0]             stride_mag;
    logic [ERR_W-1:0]        err_mag;
    logic [PV_W-1:0]         integ_mag;
    logic signed [SUM_W-1:0] sp_prod;
    logic signed [SUM_W-1:0] sp_sum;
    logic signed [SUM_W-1:0] quot_s;

    t_div_req div_req;
    t_div_rsp div_rsp;

    pilp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign per_eff  = (r_period == 16'd0) ? 16'd1 : r_period;
    assign tau_eff  = (r_tau == 16'd0) ? 16'd1 : r_tau;
    assign dlim_eff = ({1'b0, r_drive_lim} > LIMIT_MAX) ? LIMIT_MAX : {1'b0, r_drive_lim};
    assign ilim_eff = ({1'b0, r_integ_lim} > LIMIT_MAX) ? LIMIT_MAX : {1'b0, r_integ_lim};

    assign gap     = r_first ? NOW_W'(per_eff) : (i_now_ms - r_last_stamp);
    assign dt_next = (gap == '0) ? per_eff : ((gap > DT_CAP) ? 16'hFFFF : gap[15:0]);

    assign stride_mag = r_sp_stride[18] ? 19'(-r_sp_stride) : 19'(r_sp_stride);
    assign err_mag    = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign integ_mag  = r_integ[PV_W-1] ? PV_W'(-r_integ) : PV_W'(r_integ);

    // shared multiplier
    assign mul_p = mul_a * mul_b;

    assign sp_prod = r_sp_stride[18] ? -$signed({{(SUM_W-MUL_P_W){1'b0}}, mul_p})
                                     :  $signed({{(SUM_W-MUL_P_W){1'b0}}, mul_p});
    assign sp_sum  = SUM_W'(r_sp_base) + sp_prod;
    assign quot_s  = SUM_W'($signed(div_rsp.quot));

    assign in_accept = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_accept)    n_state = S_HOLD_DIV;
            S_HOLD_DIV: if (div_rsp.done) n_state = S_STEP_DIV;
            S_STEP_DIV: if (div_rsp.done) n_state = S_SP;
            S_SP:                         n_state = S_ERR;
            S_ERR:                        n_state = S_INT_MUL;
            S_INT_MUL:                    n_state = S_INT_DIV;
            S_INT_DIV:  if (div_rsp.done) n_state = S_P_DIV;
            S_P_DIV:    if (div_rsp.done) n_state = S_I_MUL;
            S_I_MUL:                      n_state = S_I_DIV;
            S_I_DIV:    if (div_rsp.done) n_state = S_DIFF;
            S_DIFF:                       n_state = S_PV_MUL;
            S_PV_MUL:                     n_state = S_PV_DIV;
            S_PV_DIV:   if (div_rsp.done) n_state = S_DONE;
            S_DONE:     if (out_load)     n_state = S_IDLE;
            default:                      n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: operand selection and divider starts
    always_comb begin
        o_in_ready       = 1'b0;
        out_load         = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.neg      = 1'b0;
        div_req.dividend = mul_p;
        div_req.divisor  = MILLI;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                div_req.start    = i_in_valid;
                div_req.dividend = DIVD_W'(i_now_ms);
                div_req.divisor  = HOLD_MS;
            end
            S_HOLD_DIV: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = div_rsp.quot[DIVD_W-1:0];
                div_req.divisor  = PROFILE_STEPS;
            end
            S_SP: begin
                mul_a = MUL_A_W'(stride_mag);
                mul_b = MUL_B_W'(r_idx);
            end
            S_INT_MUL: begin
                mul_a         = err_mag[MUL_A_W-1:0];
                mul_b         = r_dt;
                div_req.start = 1'b1;
                div_req.neg   = r_err[ERR_W-1];
            end
            // proportional term starts as soon as the integral divide ends
            S_INT_DIV: begin
                mul_a         = err_mag[MUL_A_W-1:0];
                mul_b         = r_prop_gain;
                div_req.start = div_rsp.done;
                div_req.neg   = r_err[ERR_W-1];
            end
            S_I_MUL: begin
                mul_a         = MUL_A_W'(integ_mag);
                mul_b         = r_integ_gain;
                div_req.start = 1'b1;
                div_req.neg   = r_integ[PV_W-1];
            end
            S_PV_MUL: begin
                mul_a           = err_mag[MUL_A_W-1:0];
                mul_b           = r_dt;
                div_req.start   = 1'b1;
                div_req.neg     = r_err[ERR_W-1];
                div_req.divisor = tau_eff;
            end
            S_DONE: begin
                out_load = !r_o_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    // control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_o_valid    <= 1'b0;
            r_prop_gain  <= RST_PROP_GAIN;
            r_integ_gain <= RST_INTEG_GAIN;
            r_tau        <= RST_TAU;
            r_drive_lim  <= RST_DRIVE_LIM;
            r_integ_lim  <= RST_INTEG_LIM;
            r_period     <= RST_PERIOD;
            r_sp_base    <= RST_SP_BASE;
            r_sp_stride  <= RST_SP_STRIDE;
            r_first      <= 1'b1;
            r_last_stamp <= '0;
            r_pv         <= '0;
            r_integ      <= '0;
            r_worst      <= '0;
            r_overruns   <= '0;
            r_iterations <= '0;
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[15:0];
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[15:0];
                    CFG_PLANT_TAU:  r_tau        <= i_cfg_data[15:0];
                    CFG_DRIVE_LIM:  r_drive_lim  <= i_cfg_data[19:0];
                    CFG_INTEG_LIM:  r_integ_lim  <= i_cfg_data[19:0];
                    CFG_PERIOD:     r_period     <= i_cfg_data[15:0];
                    CFG_SP_BASE:    r_sp_base    <= $signed(i_cfg_data[20:0]);
                    CFG_SP_STRIDE:  r_sp_stride  <= $signed(i_cfg_data[18:0]);
                endcase
            end

            if (in_accept) begin
                r_first      <= 1'b0;
                r_last_stamp <= i_now_ms;
                r_iterations <= r_iterations + NOW_W'(1);
                if (gap > r_worst) begin
                    r_worst <= gap;
                end
                if (gap > NOW_W'({per_eff, 1'b0})) begin
                    r_overruns <= r_overruns + NOW_W'(1);
                end
            end

            if (r_state == S_INT_DIV && div_rsp.done) begin
                r_integ <= PV_W'(clamp_sym(SUM_W'(r_integ) + quot_s, ilim_eff));
            end
            if (r_state == S_PV_DIV && div_rsp.done) begin
                r_pv <= PV_W'(clamp_sym(SUM_W'(r_pv) + quot_s, PV_MAX));
            end
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_gap <= gap;
            r_dt  <= dt_next;
        end
        if (r_state == S_STEP_DIV && div_rsp.done) begin
            r_idx <= div_rsp.rem[IDX_W-1:0];
        end
        if (r_state == S_SP) begin
            r_sp <= SP_W'(clamp_sym(sp_sum, SP_MAX));
        end
        if (r_state == S_ERR) begin
            r_err <= ERR_W'(SUM_W'(r_sp) - SUM_W'(r_pv));
        end
        if (r_state == S_P_DIV && div_rsp.done) begin
            r_up <= UP_W'(quot_s);
        end
        if (r_state == S_I_DIV && div_rsp.done) begin
            r_u <= PV_W'(clamp_sym(SUM_W'(r_up) + quot_s, dlim_eff));
        end
        // err register is reused for drive minus plant value
        if (r_state == S_DIFF) begin
            r_err <= ERR_W'(SUM_W'(r_u) - SUM_W'(r_pv));
        end
        if (out_load) begin
            r_o_sp         <= r_sp;
            r_o_pv         <= r_pv;
            r_o_u          <= r_u;
            r_o_integ      <= r_integ;
            r_o_gap        <= r_gap;
            r_o_worst      <= r_worst;
            r_o_overruns   <= r_overruns;
            r_o_iterations <= r_iterations;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_setpoint_milli  = r_o_sp;
    assign o_measured_milli  = r_o_pv;
    assign o_drive_milli     = r_o_u;
    assign o_integral_milli  = r_o_integ;
    assign o_gap_ms          = r_o_gap;
    assign o_worst_gap_ms    = r_o_worst;
    assign o_overrun_count   = r_o_overruns;
    assign o_iteration_count = r_o_iterations;

    `ASSERT_CLKD(a_div_done_in_wait, i_clk, i_rst_n, div_rsp.done |-> (r_state == S_HOLD_DIV || r_state == S_STEP_DIV || r_state == S_INT_DIV || r_state == S_P_DIV || r_state == S_I_DIV || r_state == S_PV_DIV), "divider finished outside a wait state")
    `ASSERT_CLKD(a_iter_step, i_clk, i_rst_n, in_accept |=> (r_iterations == $past(r_iterations) + NOW_W'(1)), "iteration count did not advance on item")
    `ASSERT_CLKD(a_integ_bound, i_clk, i_rst_n, (SUM_W'(r_integ) <= INTEG_BOUND) && (SUM_W'(r_integ) >= -INTEG_BOUND), "integral left its clamp range")
    `ASSERT_CLKD(a_pv_bound, i_clk, i_rst_n, (SUM_W'(r_pv) <= PV_BOUND) && (SUM_W'(r_pv) >= -PV_BOUND), "plant value left its clamp range")

endmodule
